// ----- rtl/ata_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ata_pkg
// widths, fixed-point constants and the micro-rotation angle table for the
// accelerometer tilt angle pipeline
// ----------------------------------------------------------------------------
package ata_pkg;

    localparam int AXIS_W           = 16;
    localparam int SCALED_W         = 10;
    localparam int SCALE_SHIFT      = 6;
    localparam int DATA_SHIFT       = 24;
    localparam int DATA_W           = 36;
    localparam int ANG_FRAC         = 16;
    localparam int ANG_W            = 26;
    localparam int THETA_W          = ANG_W - ANG_FRAC;
    localparam int TILT_W           = 9;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    localparam logic signed [ANG_W-1:0] ANG_POS_90   = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_NEG_90   = -ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_POS_180  = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_NEG_180  = -ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_ZERO     = '0;
    localparam logic signed [ANG_W-1:0] ANG_FRAC_MSK = ANG_W'((1 << ANG_FRAC) - 1);

    localparam logic signed [AXIS_W-1:0] SCALE_BIAS =
        AXIS_W'((1 << SCALE_SHIFT) - 1);

    localparam logic signed [THETA_W-1:0] WRAP_LIMIT = -THETA_W'(135);
    localparam logic signed [THETA_W-1:0] WRAP_ADD   = THETA_W'(360);

    // atan(2^-i) in degrees, q.16, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_deg_q16(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:       val = ANG_W'(2949120);
            1:       val = ANG_W'(1740967);
            2:       val = ANG_W'(919879);
            3:       val = ANG_W'(466945);
            4:       val = ANG_W'(234379);
            5:       val = ANG_W'(117304);
            6:       val = ANG_W'(58666);
            7:       val = ANG_W'(29335);
            8:       val = ANG_W'(14668);
            9:       val = ANG_W'(7334);
            10:      val = ANG_W'(3667);
            11:      val = ANG_W'(1833);
            12:      val = ANG_W'(917);
            13:      val = ANG_W'(458);
            14:      val = ANG_W'(229);
            15:      val = ANG_W'(115);
            16:      val = ANG_W'(57);
            17:      val = ANG_W'(29);
            18:      val = ANG_W'(14);
            19:      val = ANG_W'(7);
            20:      val = ANG_W'(4);
            21:      val = ANG_W'(2);
            22:      val = ANG_W'(1);
            default: val = ANG_W'(0);
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/accel_tilt_angle_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angle_top
// tilt angle atan2(y, z) in whole degrees from one raw three-axis
// accelerometer sample, computed by a pipelined vectoring cordic
// ----------------------------------------------------------------------------
// The block accepts one sample per clock cycle while in_stall is low and
// returns one result per sample, in order. One stage scales the axes and
// folds the vector into the right half plane, one stage per cordic
// micro-rotation, and one stage turns the angle into wrapped whole degrees.
// A stalled output holds only the stages that are full; empty stages still
// take new samples. When all three scaled axes are zero the angle reads 0 and
// angle_valid is low.
module accel_tilt_angle_top #(
    parameter int CORDIC_STEPS = ata_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic signed [ata_pkg::AXIS_W-1:0]  accel_x,
    input  wire logic signed [ata_pkg::AXIS_W-1:0]  accel_y,
    input  wire logic signed [ata_pkg::AXIS_W-1:0]  accel_z,
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      logic signed [ata_pkg::TILT_W-1:0]  tilt_degrees,
    output      logic                               angle_valid
);

    localparam int NS = CORDIC_STEPS;
    localparam int DW = ata_pkg::DATA_W;
    localparam int AW = ata_pkg::ANG_W;
    localparam int SW = ata_pkg::SCALED_W;
    localparam int XW = ata_pkg::AXIS_W;
    localparam int TW = ata_pkg::THETA_W;

    logic signed [DW-1:0] x_reg   [0:NS];
    logic signed [DW-1:0] y_reg   [0:NS];
    logic signed [AW-1:0] acc_reg [0:NS];
    logic                 ok_reg  [0:NS];
    logic [NS:0]          valid_reg;
    logic [NS+1:0]        ready;

    logic                 out_valid_reg;
    logic signed [ata_pkg::TILT_W-1:0] tilt_reg;
    logic                 angle_valid_reg;

    // per-stage load enables, bubbles collapse under stall
    assign ready[NS+1] = !out_valid_reg || !out_stall;
    genvar g;
    generate
        for (g = 0; g <= NS; g++)
        begin : g_ready
            assign ready[g] = !valid_reg[g] || ready[g+1];
        end
    endgenerate

    assign in_stall = !ready[0];

    // input stage: scale by 1/64 toward zero, fold into x >= 0
    logic signed [XW-1:0] sum_x, sum_y, sum_z;
    logic signed [SW-1:0] sx, sy, sz;
    logic signed [DW-1:0] ey, ez;
    logic signed [DW-1:0] x0_next, y0_next;
    logic signed [AW-1:0] acc0_next;
    logic                 ok0_next;

    always_comb
    begin
        sum_x = accel_x + (accel_x[XW-1] ? ata_pkg::SCALE_BIAS : '0);
        sum_y = accel_y + (accel_y[XW-1] ? ata_pkg::SCALE_BIAS : '0);
        sum_z = accel_z + (accel_z[XW-1] ? ata_pkg::SCALE_BIAS : '0);
        sx = sum_x[XW-1:ata_pkg::SCALE_SHIFT];
        sy = sum_y[XW-1:ata_pkg::SCALE_SHIFT];
        sz = sum_z[XW-1:ata_pkg::SCALE_SHIFT];
        ey = {{(DW-SW){sy[SW-1]}}, sy} <<< ata_pkg::DATA_SHIFT;
        ez = {{(DW-SW){sz[SW-1]}}, sz} <<< ata_pkg::DATA_SHIFT;
        ok0_next = (sx != '0) || (sy != '0) || (sz != '0);
        if (sz == '0)
        begin
            x0_next = '0;
            y0_next = '0;
            if (sy == '0)
                acc0_next = ata_pkg::ANG_ZERO;
            else if (sy[SW-1])
                acc0_next = ata_pkg::ANG_NEG_90;
            else
                acc0_next = ata_pkg::ANG_POS_90;
        end
        else if (!sz[SW-1])
        begin
            x0_next   = ez;
            y0_next   = ey;
            acc0_next = ata_pkg::ANG_ZERO;
        end
        else
        begin
            x0_next   = -ez;
            y0_next   = -ey;
            acc0_next = sy[SW-1] ? ata_pkg::ANG_NEG_180 : ata_pkg::ANG_POS_180;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            acc_reg[0] <= acc0_next;
            ok_reg[0]  <= ok0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (ready[0])
            valid_reg[0] <= in_valid;
    end

    // micro-rotation stages, skipped once the residual is exactly zero
    generate
        for (g = 1; g <= NS; g++)
        begin : g_step
            localparam logic signed [AW-1:0] STEP_ANG = ata_pkg::atan_deg_q16(g - 1);
            logic signed [DW-1:0] dx, dy;
            logic signed [DW-1:0] x_next, y_next;
            logic signed [AW-1:0] acc_next;

            always_comb
            begin
                dx = y_reg[g-1] >>> (g - 1);
                dy = x_reg[g-1] >>> (g - 1);
                x_next   = x_reg[g-1];
                y_next   = y_reg[g-1];
                acc_next = acc_reg[g-1];
                if (y_reg[g-1] != '0)
                begin
                    if (!y_reg[g-1][DW-1])
                    begin
                        x_next   = x_reg[g-1] + dx;
                        y_next   = y_reg[g-1] - dy;
                        acc_next = acc_reg[g-1] + STEP_ANG;
                    end
                    else
                    begin
                        x_next   = x_reg[g-1] - dx;
                        y_next   = y_reg[g-1] + dy;
                        acc_next = acc_reg[g-1] - STEP_ANG;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[g])
                begin
                    x_reg[g]   <= x_next;
                    y_reg[g]   <= y_next;
                    acc_reg[g] <= acc_next;
                    ok_reg[g]  <= ok_reg[g-1];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (ready[g])
                    valid_reg[g] <= valid_reg[g-1];
            end
        end
    endgenerate

    // output stage: truncate toward zero to whole degrees, wrap below -135
    logic signed [AW-1:0] acc_bias;
    logic signed [TW-1:0] theta, theta_wrap;

    always_comb
    begin
        acc_bias   = acc_reg[NS] + (acc_reg[NS][AW-1] ? ata_pkg::ANG_FRAC_MSK : '0);
        theta      = acc_bias[AW-1:ata_pkg::ANG_FRAC];
        theta_wrap = (theta < ata_pkg::WRAP_LIMIT) ? theta + ata_pkg::WRAP_ADD : theta;
    end

    always_ff @(posedge clk)
    begin
        if (ready[NS+1])
        begin
            tilt_reg        <= theta_wrap[ata_pkg::TILT_W-1:0];
            angle_valid_reg <= ok_reg[NS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready[NS+1])
            out_valid_reg <= valid_reg[NS];
    end

    assign out_valid    = out_valid_reg;
    assign tilt_degrees = tilt_reg;
    assign angle_valid  = angle_valid_reg;

endmodule
`default_nettype wire
